[src/cebi_pkg.sv]
// Shared constants for the circle elastic bounce impulse block.
// No dependencies.
package cebi_pkg;

  // Default word width of positions, velocities, masses and results.
  localparam int WORD_BITS_DEF = 32;

  // Register stages through one cebi_mul instance.
  localparam int MUL_LAT = 3;

endpackage

[src/cebi_mul.sv]
// Pipelined unsigned multiplier built from chunk products, three register stages.
// Standalone; used by circle_elastic_bounce_impulse. Requires BW <= 2*CB.
module cebi_mul #(
  parameter int AW = 32,
  parameter int BW = 32,
  parameter int CB = 17
) (
  input  logic               clk,
  input  logic               en,
  input  logic [AW-1:0]      a,
  input  logic [BW-1:0]      b,
  output logic [AW+BW-1:0]   p
);

  localparam int NA = (AW + CB - 1) / CB;
  localparam int AP = NA * CB;
  localparam int RW = AP + CB;
  localparam int SW = RW + CB;

  logic [AP-1:0]     apad;
  logic [2*CB-1:0]   bpad;
  logic [2*CB-1:0]   pp [NA][2];
  logic [RW-1:0]     ev [2];
  logic [RW-1:0]     od [2];
  logic [RW-1:0]     row [2];
  logic [SW-1:0]     psum;

  assign apad = AP'(a);
  assign bpad = (2*CB)'(b);

  // stage 1: chunk products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < 2; j++) begin
          pp[i][j] <= apad[i*CB +: CB] * bpad[j*CB +: CB];
        end
      end
    end
  end

  // even and odd chunks of one row do not overlap, so each packs by concatenation
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      ev[j] = '0;
      od[j] = '0;
      for (int i = 0; i < NA; i++) begin
        if (i % 2 == 0) begin
          ev[j][i*CB +: 2*CB] = pp[i][j];
        end else begin
          od[j][i*CB +: 2*CB] = pp[i][j];
        end
      end
    end
  end

  // stage 2: one row per half of b
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 2; j++) begin
        row[j] <= ev[j] + od[j];
      end
    end
  end

  // stage 3: combine rows
  always_ff @(posedge clk) begin
    if (en) begin
      psum <= SW'(row[0]) + (SW'(row[1]) << CB);
    end
  end

  assign p = psum[AW+BW-1:0];

endmodule

[src/circle_elastic_bounce_impulse.sv]
// Elastic bounce impulse for two circles in the x/z plane, fully pipelined.
// Depends on cebi_pkg and cebi_mul.
//
// Each request carries both contact points, both velocities and both masses
// and yields one result: impulse = -2*m_t*((v_p-v_t).d)*d / ((m_p+m_t)*|d|^2)
// with d = p_p - p_t, or d = (1,0) when the points coincide, truncated toward
// zero and saturated to the word range (clipped flags it). A zero mass sum
// gives a zero impulse and sets mass_sum_zero. The scale of the fixed point
// format cancels, so any binary point position gives the same bits. One
// request is taken every cycle while in_ready is high. Each request passes
// through three chained multiplier pipelines of three stages each and a
// restoring divider that resolves one quotient bit per stage. An output
// register with a skid stage takes one more result while a result waits on
// out_ready; once the skid is full, the pipeline stalls and in_ready drops.
module circle_elastic_bounce_impulse import cebi_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [WORD_BITS-1:0] pusher_pos_x,
  input  logic signed [WORD_BITS-1:0] pusher_pos_z,
  input  logic signed [WORD_BITS-1:0] target_pos_x,
  input  logic signed [WORD_BITS-1:0] target_pos_z,
  input  logic signed [WORD_BITS-1:0] pusher_vel_x,
  input  logic signed [WORD_BITS-1:0] pusher_vel_z,
  input  logic signed [WORD_BITS-1:0] target_vel_x,
  input  logic signed [WORD_BITS-1:0] target_vel_z,
  input  logic        [WORD_BITS-2:0] pusher_mass,
  input  logic        [WORD_BITS-2:0] target_mass,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [WORD_BITS-1:0] impulse_x,
  output logic signed [WORD_BITS-1:0] impulse_z,
  output logic                        clipped,
  output logic                        mass_sum_zero
);

  localparam int W    = WORD_BITS;
  localparam int DW   = W + 1;
  localparam int CB   = (W + 2) / 2;
  localparam int PW   = 2 * DW;
  localparam int DOTW = PW + 1;
  localparam int DMW  = PW + W - 1;
  localparam int DENW = PW + W;
  localparam int NUMW = DMW + DW;
  localparam int XW   = NUMW + 1;
  localparam int LAT  = 7 + 3 * MUL_LAT + W;

  typedef struct packed {
    logic          px;
    logic          pz;
    logic          ndx;
    logic          ndz;
    logic [DW-1:0] adx;
    logic [DW-1:0] adz;
    logic [W-1:0]  msum;
    logic [W-2:0]  m2;
    logic          msz;
  } side1_t;

  typedef struct packed {
    logic          ndx;
    logic          ndz;
    logic [DW-1:0] adx;
    logic [DW-1:0] adz;
    logic [W-1:0]  msum;
    logic [W-2:0]  m2;
    logic          msz;
  } side2_t;

  typedef struct packed {
    logic          rnx;
    logic          rnz;
    logic [DW-1:0] adx;
    logic [DW-1:0] adz;
    logic          msz;
  } side3_t;

  typedef struct packed {
    logic [DENW-1:0] den;
    logic            rnx;
    logic            rnz;
    logic            msz;
  } side4_t;

  typedef struct packed {
    logic ovx;
    logic ovz;
    logic rnx;
    logic rnz;
    logic msz;
  } dside_t;

  typedef struct packed {
    logic [W-1:0] ix;
    logic [W-1:0] iz;
    logic         clip;
    logic         msz;
  } res_t;

  logic           en;
  logic           skid_valid;
  logic [LAT-1:0] vpipe;

  assign en       = !skid_valid;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[LAT-2:0], in_valid};
    end
  end

  // stage 1: differences and mass sum
  logic [DW-1:0] s1_dx, s1_dz, s1_dvx, s1_dvz;
  logic [W-1:0]  s1_msum;
  logic [W-2:0]  s1_m2;
  logic          s1_msz;
  logic          same_pt;

  assign same_pt = (pusher_pos_x == target_pos_x) && (pusher_pos_z == target_pos_z);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx   <= same_pt ? DW'(1) : DW'(pusher_pos_x) - DW'(target_pos_x);
      s1_dz   <= same_pt ? '0 : DW'(pusher_pos_z) - DW'(target_pos_z);
      s1_dvx  <= DW'(pusher_vel_x) - DW'(target_vel_x);
      s1_dvz  <= DW'(pusher_vel_z) - DW'(target_vel_z);
      s1_msum <= W'(pusher_mass) + W'(target_mass);
      s1_m2   <= target_mass;
      s1_msz  <= (pusher_mass == '0) && (target_mass == '0);
    end
  end

  // stage 2: magnitudes and signs
  logic [DW-1:0] s2_advx, s2_advz;
  side1_t        s2_side;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_advx      <= s1_dvx[DW-1] ? ~s1_dvx + 1'b1 : s1_dvx;
      s2_advz      <= s1_dvz[DW-1] ? ~s1_dvz + 1'b1 : s1_dvz;
      s2_side.adx  <= s1_dx[DW-1] ? ~s1_dx + 1'b1 : s1_dx;
      s2_side.adz  <= s1_dz[DW-1] ? ~s1_dz + 1'b1 : s1_dz;
      s2_side.px   <= s1_dx[DW-1] ^ s1_dvx[DW-1];
      s2_side.pz   <= s1_dz[DW-1] ^ s1_dvz[DW-1];
      s2_side.ndx  <= s1_dx[DW-1];
      s2_side.ndz  <= s1_dz[DW-1];
      s2_side.msum <= s1_msum;
      s2_side.m2   <= s1_m2;
      s2_side.msz  <= s1_msz;
    end
  end

  // dot product terms and squared distance terms
  logic [PW-1:0] uxv, uzv, sxx, szz;

  cebi_mul #(.AW(DW), .BW(DW), .CB(CB)) u_mul_xv (
    .clk(clk), .en(en), .a(s2_side.adx), .b(s2_advx), .p(uxv)
  );
  cebi_mul #(.AW(DW), .BW(DW), .CB(CB)) u_mul_zv (
    .clk(clk), .en(en), .a(s2_side.adz), .b(s2_advz), .p(uzv)
  );
  cebi_mul #(.AW(DW), .BW(DW), .CB(CB)) u_mul_xx (
    .clk(clk), .en(en), .a(s2_side.adx), .b(s2_side.adx), .p(sxx)
  );
  cebi_mul #(.AW(DW), .BW(DW), .CB(CB)) u_mul_zz (
    .clk(clk), .en(en), .a(s2_side.adz), .b(s2_side.adz), .p(szz)
  );

  side1_t d1 [MUL_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      d1[0] <= s2_side;
      for (int k = 1; k < MUL_LAT; k++) begin
        d1[k] <= d1[k-1];
      end
    end
  end

  // stage 6: signed terms, squared distance
  logic [DOTW-1:0] s6_tx, s6_tz;
  logic [DOTW-1:0] txe, tze;
  logic [PW-1:0]   s6_sq;
  side2_t          s6_side;

  assign txe = {1'b0, uxv};
  assign tze = {1'b0, uzv};

  always_ff @(posedge clk) begin
    if (en) begin
      s6_tx        <= d1[MUL_LAT-1].px ? ~txe + 1'b1 : txe;
      s6_tz        <= d1[MUL_LAT-1].pz ? ~tze + 1'b1 : tze;
      s6_sq        <= sxx + szz;
      s6_side.ndx  <= d1[MUL_LAT-1].ndx;
      s6_side.ndz  <= d1[MUL_LAT-1].ndz;
      s6_side.adx  <= d1[MUL_LAT-1].adx;
      s6_side.adz  <= d1[MUL_LAT-1].adz;
      s6_side.msum <= d1[MUL_LAT-1].msum;
      s6_side.m2   <= d1[MUL_LAT-1].m2;
      s6_side.msz  <= d1[MUL_LAT-1].msz;
    end
  end

  // stage 7: dot product
  logic [DOTW-1:0] s7_dot;
  logic [PW-1:0]   s7_sq;
  side2_t          s7_side;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_dot  <= s6_tx + s6_tz;
      s7_sq   <= s6_sq;
      s7_side <= s6_side;
    end
  end

  // stage 8: dot magnitude; result is negative when the numerator is positive
  logic [PW-1:0] s8_dmag;
  logic [PW-1:0] s8_sq;
  logic [W-1:0]  s8_msum;
  logic [W-2:0]  s8_m2;
  side3_t        s8_side;

  always_ff @(posedge clk) begin
    if (en) begin
      s8_dmag     <= s7_dot[DOTW-1] ? PW'(~s7_dot + 1'b1) : PW'(s7_dot);
      s8_sq       <= s7_sq;
      s8_msum     <= s7_side.msum;
      s8_m2       <= s7_side.m2;
      s8_side.rnx <= !(s7_dot[DOTW-1] ^ s7_side.ndx);
      s8_side.rnz <= !(s7_dot[DOTW-1] ^ s7_side.ndz);
      s8_side.adx <= s7_side.adx;
      s8_side.adz <= s7_side.adz;
      s8_side.msz <= s7_side.msz;
    end
  end

  logic [DMW-1:0]  dm;
  logic [DENW-1:0] den;

  cebi_mul #(.AW(PW), .BW(W-1), .CB(CB)) u_mul_dm (
    .clk(clk), .en(en), .a(s8_dmag), .b(s8_m2), .p(dm)
  );
  cebi_mul #(.AW(PW), .BW(W), .CB(CB)) u_mul_den (
    .clk(clk), .en(en), .a(s8_sq), .b(s8_msum), .p(den)
  );

  side3_t d3 [MUL_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      d3[0] <= s8_side;
      for (int k = 1; k < MUL_LAT; k++) begin
        d3[k] <= d3[k-1];
      end
    end
  end

  logic [NUMW-1:0] numx, numz;

  cebi_mul #(.AW(DMW), .BW(DW), .CB(CB)) u_mul_nx (
    .clk(clk), .en(en), .a(dm), .b(d3[MUL_LAT-1].adx), .p(numx)
  );
  cebi_mul #(.AW(DMW), .BW(DW), .CB(CB)) u_mul_nz (
    .clk(clk), .en(en), .a(dm), .b(d3[MUL_LAT-1].adz), .p(numz)
  );

  side4_t d4 [MUL_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      d4[0].den <= den;
      d4[0].rnx <= d3[MUL_LAT-1].rnx;
      d4[0].rnz <= d3[MUL_LAT-1].rnz;
      d4[0].msz <= d3[MUL_LAT-1].msz;
      for (int k = 1; k < MUL_LAT; k++) begin
        d4[k] <= d4[k-1];
      end
    end
  end

  // divider: entry stage flags quotients of 2^W or more, then one bit per stage
  logic [XW-1:0]   magx, magz, dtop;
  logic [XW-1:0]   rx [W];
  logic [XW-1:0]   rz [W];
  logic [DENW-1:0] dn [W];
  logic [W-1:0]    qx [W+1];
  logic [W-1:0]    qz [W+1];
  dside_t          ds [W+1];

  assign magx = {numx, 1'b0};
  assign magz = {numz, 1'b0};
  assign dtop = XW'(d4[MUL_LAT-1].den) << W;

  always_ff @(posedge clk) begin
    if (en) begin
      rx[0]     <= magx;
      rz[0]     <= magz;
      dn[0]     <= d4[MUL_LAT-1].den;
      qx[0]     <= '0;
      qz[0]     <= '0;
      ds[0].ovx <= magx >= dtop;
      ds[0].ovz <= magz >= dtop;
      ds[0].rnx <= d4[MUL_LAT-1].rnx;
      ds[0].rnz <= d4[MUL_LAT-1].rnz;
      ds[0].msz <= d4[MUL_LAT-1].msz;
    end
  end

  for (genvar i = 0; i < W; i++) begin : g_div
    localparam int K = W - 1 - i;
    logic [XW-1:0] dsh;
    logic          gex, gez;

    assign dsh = XW'(dn[i]) << K;
    assign gex = rx[i] >= dsh;
    assign gez = rz[i] >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        qx[i+1] <= qx[i] | (gex ? W'(1) << K : '0);
        qz[i+1] <= qz[i] | (gez ? W'(1) << K : '0);
        ds[i+1] <= ds[i];
      end
    end

    if (i < W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rx[i+1] <= gex ? rx[i] - dsh : rx[i];
          rz[i+1] <= gez ? rz[i] - dsh : rz[i];
          dn[i+1] <= dn[i];
        end
      end
    end
  end

  // final stage: saturate, apply sign, zero-mass override
  logic [W-1:0] lim_x, lim_z, mq_x, mq_z, vx, vz;
  logic         sat_x, sat_z;
  res_t         fin, fin_d, out_d, skid_d;

  always_comb begin
    lim_x = {1'b0, {(W-1){1'b1}}} + W'(ds[W].rnx);
    lim_z = {1'b0, {(W-1){1'b1}}} + W'(ds[W].rnz);
    sat_x = ds[W].ovx || (qx[W] > lim_x);
    sat_z = ds[W].ovz || (qz[W] > lim_z);
    mq_x  = sat_x ? lim_x : qx[W];
    mq_z  = sat_z ? lim_z : qz[W];
    vx    = ds[W].rnx ? ~mq_x + 1'b1 : mq_x;
    vz    = ds[W].rnz ? ~mq_z + 1'b1 : mq_z;
    fin_d.ix   = ds[W].msz ? '0 : vx;
    fin_d.iz   = ds[W].msz ? '0 : vz;
    fin_d.clip = !ds[W].msz && (sat_x || sat_z);
    fin_d.msz  = ds[W].msz;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin <= fin_d;
    end
  end

  // output register plus skid; the skid fills only while the output is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_ready) begin
      if (en && vpipe[LAT-1]) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= vpipe[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_ready) begin
      if (en) begin
        skid_d <= fin;
      end
    end else if (skid_valid) begin
      out_d <= skid_d;
    end else begin
      out_d <= fin;
    end
  end

  assign impulse_x     = out_d.ix;
  assign impulse_z     = out_d.iz;
  assign clipped       = out_d.clip;
  assign mass_sum_zero = out_d.msz;

endmodule

[bench/testbench.sv]
// Self-checking bench for circle_elastic_bounce_impulse: random and directed contact pairs,
// random stalls on both channels, with an in-bench impulse predictor and scoreboard.
// Depends on cebi_pkg and the block's RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cebi_pkg::*;

  localparam int W = WORD_BITS_DEF;
  localparam int WIDE = 5 * W;
  localparam int PIPE_DEPTH = W + 16;
  localparam int HOLD_CYCLES = 400;

  typedef logic signed [W-1:0] word_t;
  typedef logic [W-2:0] mass_t;
  typedef logic signed [WIDE-1:0] wide_t;

  localparam wide_t WORD_MAX = (wide_t'(1) <<< (W - 1)) - 1;
  localparam wide_t WORD_MIN = -(wide_t'(1) <<< (W - 1));
  localparam word_t ONE = 32'sh0001_0000;
  localparam word_t MAXW = 32'sh7fff_ffff;
  localparam word_t MINW = 32'sh8000_0000;
  localparam mass_t MMAX = '1;

  typedef struct {
    word_t pusher_pos_x, pusher_pos_z, target_pos_x, target_pos_z;
    word_t pusher_vel_x, pusher_vel_z, target_vel_x, target_vel_z;
    mass_t pusher_mass, target_mass;
  } contact_t;

  typedef struct {
    word_t impulse_x, impulse_z;
    logic  clipped, mass_sum_zero;
  } impulse_t;

  typedef enum {ANY_BITS, PHYSICAL, TOUCHING, TINY, CORNERS} pattern_e;

  class impulse_checker;
    impulse_t pending[$];
    int unsigned mismatches, requests, checked, saturated, massless, coincident;

    function word_t clamp_word(wide_t q, inout logic clip);
      clamp_word = q[W-1:0];
      if (q > WORD_MAX) begin
        clip = 1'b1;
        clamp_word = WORD_MAX[W-1:0];
      end else if (q < WORD_MIN) begin
        clip = 1'b1;
        clamp_word = WORD_MIN[W-1:0];
      end
    endfunction

    // Square-root-free form; the Q scale cancels, so raw integers are used directly.
    function impulse_t bounce_impulse(contact_t c);
      wide_t dx, dz, dvx, dvz, m_t, m_sum, dot2m, den;
      logic clip;
      impulse_t r;
      clip = 1'b0;
      r.impulse_x = '0;
      r.impulse_z = '0;
      r.clipped = 1'b0;
      r.mass_sum_zero = 1'b0;
      m_t = c.target_mass;
      m_sum = c.pusher_mass;
      m_sum = m_sum + m_t;
      if (m_sum == 0) begin
        r.mass_sum_zero = 1'b1;
      end else begin
        dx = c.pusher_pos_x - c.target_pos_x;
        dz = c.pusher_pos_z - c.target_pos_z;
        if (dx == 0 && dz == 0) dx = 1;
        dvx = c.pusher_vel_x - c.target_vel_x;
        dvz = c.pusher_vel_z - c.target_vel_z;
        dot2m = 2 * m_t * (dvx * dx + dvz * dz);
        den = m_sum * (dx * dx + dz * dz);
        // signed division truncates toward zero
        r.impulse_x = clamp_word(-(dot2m * dx) / den, clip);
        r.impulse_z = clamp_word(-(dot2m * dz) / den, clip);
        r.clipped = clip;
      end
      return r;
    endfunction

    function void note_request(contact_t c);
      impulse_t want;
      want = bounce_impulse(c);
      requests++;
      if (want.clipped) saturated++;
      if (want.mass_sum_zero) massless++;
      if (c.pusher_pos_x == c.target_pos_x && c.pusher_pos_z == c.target_pos_z) coincident++;
      pending.push_back(want);
    endfunction

    function void check_result(impulse_t got);
      impulse_t want;
      if (pending.size() == 0) begin
        $display("%0t: result with no request outstanding: x %0d z %0d clipped %0b msz %0b",
                 $time, got.impulse_x, got.impulse_z, got.clipped, got.mass_sum_zero);
        mismatches++;
      end else begin
        want = pending.pop_front();
        checked++;
        if (got.impulse_x !== want.impulse_x) begin
          $display("%0t: impulse_x expected %0d, actual %0d", $time, want.impulse_x,
                   got.impulse_x);
          mismatches++;
        end
        if (got.impulse_z !== want.impulse_z) begin
          $display("%0t: impulse_z expected %0d, actual %0d", $time, want.impulse_z,
                   got.impulse_z);
          mismatches++;
        end
        if (got.clipped !== want.clipped) begin
          $display("%0t: clipped expected %0b, actual %0b", $time, want.clipped, got.clipped);
          mismatches++;
        end
        if (got.mass_sum_zero !== want.mass_sum_zero) begin
          $display("%0t: mass_sum_zero expected %0b, actual %0b", $time, want.mass_sum_zero,
                   got.mass_sum_zero);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_ready;
  word_t pusher_pos_x = '0, pusher_pos_z = '0, target_pos_x = '0, target_pos_z = '0;
  word_t pusher_vel_x = '0, pusher_vel_z = '0, target_vel_x = '0, target_vel_z = '0;
  mass_t pusher_mass = '0, target_mass = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  word_t impulse_x, impulse_z;
  logic  clipped, mass_sum_zero;

  bit steady = 1'b0;
  bit hold_pending = 1'b0;
  impulse_checker board = new;

  circle_elastic_bounce_impulse dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin : watch_requests
    contact_t c;
    if (!rst && in_valid && in_ready) begin
      c.pusher_pos_x = pusher_pos_x;
      c.pusher_pos_z = pusher_pos_z;
      c.target_pos_x = target_pos_x;
      c.target_pos_z = target_pos_z;
      c.pusher_vel_x = pusher_vel_x;
      c.pusher_vel_z = pusher_vel_z;
      c.target_vel_x = target_vel_x;
      c.target_vel_z = target_vel_z;
      c.pusher_mass = pusher_mass;
      c.target_mass = target_mass;
      board.note_request(c);
    end
  end

  always @(posedge clk) begin : watch_results
    impulse_t got;
    if (!rst && out_valid && out_ready) begin
      got.impulse_x = impulse_x;
      got.impulse_z = impulse_z;
      got.clipped = clipped;
      got.mass_sum_zero = mass_sum_zero;
      board.check_result(got);
    end
  end

  // Receiver: random back-pressure, optional long hold-off counted here.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 37);
      end
    end
  end

  initial begin
    #1_000_000;
    $display("Timeout with %0d results still outstanding", board.pending.size());
    $display("Simulation FAILED");
    $finish;
  end

  function automatic contact_t contact_of(word_t ppx, word_t ppz, word_t tpx, word_t tpz,
                                          word_t pvx, word_t pvz, word_t tvx, word_t tvz,
                                          mass_t m_p, mass_t m_t);
    contact_t c;
    c.pusher_pos_x = ppx;
    c.pusher_pos_z = ppz;
    c.target_pos_x = tpx;
    c.target_pos_z = tpz;
    c.pusher_vel_x = pvx;
    c.pusher_vel_z = pvz;
    c.target_vel_x = tvx;
    c.target_vel_z = tvz;
    c.pusher_mass = m_p;
    c.target_mass = m_t;
    return c;
  endfunction

  // Signed random confined to +/- 2^(bits-1).
  function automatic word_t rand_span(int bits);
    return word_t'($signed($urandom) >>> (W - bits));
  endfunction

  function automatic word_t corner_word();
    case ($urandom_range(5))
      0: return MINW;
      1: return MAXW;
      2: return '0;
      3: return -1;
      4: return 1;
      default: return $urandom;
    endcase
  endfunction

  function automatic mass_t corner_mass();
    case ($urandom_range(3))
      0: return '0;
      1: return MMAX;
      2: return 1;
      default: return $urandom;
    endcase
  endfunction

  function automatic pattern_e pick_pattern();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 30) return ANY_BITS;
    if (roll < 70) return PHYSICAL;
    if (roll < 80) return TOUCHING;
    if (roll < 90) return TINY;
    return CORNERS;
  endfunction

  function automatic contact_t make_contact(pattern_e kind);
    contact_t c;
    case (kind)
      ANY_BITS: c = contact_of($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom, $urandom);
      PHYSICAL: c = contact_of(rand_span(23), rand_span(23), rand_span(23), rand_span(23),
                               rand_span(21), rand_span(21), rand_span(21), rand_span(21),
                               $urandom_range(32'h0010_0000, 1),
                               $urandom_range(32'h0010_0000, 1));
      TOUCHING: begin
        c = contact_of($urandom, $urandom, '0, '0, rand_span(21), rand_span(21),
                       rand_span(21), rand_span(21), $urandom_range(32'h0010_0000),
                       $urandom_range(32'h0010_0000, 1));
        c.target_pos_x = c.pusher_pos_x;
        c.target_pos_z = c.pusher_pos_z;
      end
      TINY: c = contact_of(rand_span(5), rand_span(5), rand_span(5), rand_span(5),
                           rand_span(5), rand_span(5), rand_span(5), rand_span(5),
                           $urandom_range(3), $urandom_range(3));
      default: c = contact_of(corner_word(), corner_word(), corner_word(), corner_word(),
                              corner_word(), corner_word(), corner_word(), corner_word(),
                              corner_mass(), corner_mass());
    endcase
    return c;
  endfunction

  task automatic send_contact(contact_t c);
    int gap;
    gap = 0;
    if (!steady) while ($urandom_range(99) < 37) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pusher_pos_x <= c.pusher_pos_x;
    pusher_pos_z <= c.pusher_pos_z;
    target_pos_x <= c.target_pos_x;
    target_pos_z <= c.target_pos_z;
    pusher_vel_x <= c.pusher_vel_x;
    pusher_vel_z <= c.pusher_vel_z;
    target_vel_x <= c.target_vel_x;
    target_vel_z <= c.target_vel_z;
    pusher_mass <= c.pusher_mass;
    target_mass <= c.target_mass;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Queue is sampled on the falling edge so the monitors have settled.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (board.pending.size() != 0);
    @(posedge clk);
  endtask

  initial begin
    contact_t directed[$];
    int n;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    directed.push_back(contact_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(contact_of(MAXW, MINW, MINW, MAXW, MAXW, MINW, MINW, MAXW, 0, 0));
    directed.push_back(contact_of(5 * ONE, -3 * ONE, 5 * ONE, -3 * ONE, ONE, 0, -ONE, 0,
                                  ONE, ONE));
    directed.push_back(contact_of(0, 0, 0, 0, 0, ONE, 0, -ONE, ONE, ONE));
    directed.push_back(contact_of(0, 0, ONE, 0, ONE, 0, 0, 0, ONE, ONE));
    directed.push_back(contact_of(0, 0, 0, ONE, 0, ONE, 0, 0, ONE, 3 * ONE));
    directed.push_back(contact_of(0, 0, ONE, ONE, ONE, 0, 0, 0, 0, ONE));
    directed.push_back(contact_of(0, 0, ONE, ONE, ONE, 0, 0, 0, ONE, 0));
    directed.push_back(contact_of(MAXW, 0, MINW, 0, MAXW, 0, MINW, 0, MMAX, MMAX));
    directed.push_back(contact_of(MAXW, 0, MINW, 0, MINW, 0, MAXW, 0, MMAX, MMAX));
    directed.push_back(contact_of(0, MAXW, 0, MINW, 0, MAXW, 0, MINW, 1, MMAX));
    directed.push_back(contact_of(3, 7, 0, 0, 5, -2, 0, 0, 1, 2));
    directed.push_back(contact_of(-3, 7, 0, 0, 5, 2, 0, 0, 2, 1));
    directed.push_back(contact_of(1, 1, 0, 0, MAXW, MAXW, 0, 0, 1, MMAX));
    directed.push_back(contact_of(-1, -1, -1, -1, -1, -1, -1, -1, MMAX, MMAX));
    directed.push_back(contact_of(0, 0, 1, 0, MINW, MINW, MAXW, MAXW, MMAX, 1));
    directed.push_back(contact_of(MINW, MINW, MAXW, MAXW, 1, -1, -1, 1, 1, 1));
    directed.push_back(contact_of(ONE, 2 * ONE, -ONE, ONE, 0, 0, 0, 0, ONE, ONE));
    foreach (directed[i]) send_contact(directed[i]);
    wait_for_results();

    for (n = 0; n < 500; n++) send_contact(make_contact(pick_pattern()));

    // back-to-back traffic with the receiver always ready
    steady = 1'b1;
    for (n = 0; n < 300; n++) send_contact(make_contact(pick_pattern()));

    // receiver stalls long enough for the pipe to fill and push back
    hold_pending = 1'b1;
    for (n = 0; n < 150; n++) send_contact(make_contact(pick_pattern()));
    steady = 1'b0;
    wait_for_results();

    for (n = 0; n < 430; n++) send_contact(make_contact(pick_pattern()));
    wait_for_results();
    repeat (PIPE_DEPTH + 16) @(posedge clk);

    $display("Checked %0d of %0d impulse requests: %0d saturated, %0d zero mass sum, %0d coincident",
             board.checked, board.requests, board.saturated, board.massless, board.coincident);
    $display("Directed corners plus random bit patterns and physical contacts, under random stalls and a %0d-cycle output hold",
             HOLD_CYCLES);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
